FILE: src/fmart_pkg.sv
// Shared types and constants for the first-match access rule table.
// Used by fmart_cell and first_match_access_rule_table.
package fmart_pkg;

    localparam int RULES_DEF     = 256;
    localparam int TYPE_BITS_DEF = 8;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_CHECK  = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_ALLOW = 2'd0,
        ST_DENY  = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Per-rule condition bits kept next to the type fields.
    typedef struct packed {
        logic subj_any;
        logic obj_any;
        logic allow;
        logic not_owner;
    } t_rule_bits;

    // Control part of a check token walking down the cell row.
    typedef struct packed {
        logic valid;
        logic uid_ne;
        logic hit;
        logic allow;
    } t_tok_flags;

endpackage

FILE: src/fmart_cell.sv
// One cell of the rule row: holds one rule and evaluates the passing check token.
// Depends on fmart_pkg.
module fmart_cell
    import fmart_pkg::*;
#(
    parameter int RULES     = RULES_DEF,
    parameter int TYPE_BITS = TYPE_BITS_DEF,
    parameter int CELL_IDX  = 0,
    localparam int CW       = $clog2(RULES + 1),
    localparam int IW       = (RULES > 1) ? $clog2(RULES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [CW-1:0]        i_wr_addr,
    input  logic [TYPE_BITS-1:0] i_wr_subj,
    input  logic [TYPE_BITS-1:0] i_wr_obj,
    input  logic [7:0]           i_wr_act,
    input  t_rule_bits           i_wr_bits,
    input  t_tok_flags           i_flags,
    input  logic [TYPE_BITS-1:0] i_subj,
    input  logic [TYPE_BITS-1:0] i_obj,
    input  logic [7:0]           i_act,
    input  logic [CW-1:0]        i_left,
    input  logic [IW-1:0]        i_idx,
    output t_tok_flags           o_flags,
    output logic [TYPE_BITS-1:0] o_subj,
    output logic [TYPE_BITS-1:0] o_obj,
    output logic [7:0]           o_act,
    output logic [CW-1:0]        o_left,
    output logic [IW-1:0]        o_idx
);

    logic [TYPE_BITS-1:0] r_subj;
    logic [TYPE_BITS-1:0] r_obj;
    logic [7:0]           r_act;
    t_rule_bits           r_bits;

    t_tok_flags           r_flags;
    logic [TYPE_BITS-1:0] r_tsubj;
    logic [TYPE_BITS-1:0] r_tobj;
    logic [7:0]           r_tact;
    logic [CW-1:0]        r_left;
    logic [IW-1:0]        r_idx;

    t_tok_flags           n_flags;
    logic [CW-1:0]        n_left;
    logic [IW-1:0]        n_idx;
    logic                 active;
    logic                 match;

    // The cell holds a live rule only while the token still has rules left to visit.
    assign active = i_flags.valid && (i_left != '0) && !i_flags.hit;
    assign match  = (r_bits.subj_any || (r_subj == i_subj))
                 && (r_bits.obj_any || (r_obj == i_obj))
                 && (r_act == i_act)
                 && !(r_bits.not_owner && !i_flags.uid_ne);

    always_comb begin
        n_flags = i_flags;
        n_idx   = i_idx;
        n_left  = (i_left != '0) ? i_left - CW'(1) : i_left;
        if (active && match) begin
            n_flags.hit   = 1'b1;
            n_flags.allow = r_bits.allow;
            n_idx         = IW'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == CW'(CELL_IDX))) begin
            r_subj <= i_wr_subj;
            r_obj  <= i_wr_obj;
            r_act  <= i_wr_act;
            r_bits <= i_wr_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tsubj <= i_subj;
        r_tobj  <= i_obj;
        r_tact  <= i_act;
        r_left  <= n_left;
        r_idx   <= n_idx;
    end

    assign o_flags = r_flags;
    assign o_subj  = r_tsubj;
    assign o_obj   = r_tobj;
    assign o_act   = r_tact;
    assign o_left  = r_left;
    assign o_idx   = r_idx;

endmodule

FILE: src/first_match_access_rule_table.sv
// Top level of the first-match access rule table: command decode, rule count
// and the row of fmart_cell stages. Depends on fmart_pkg and fmart_cell.
//
// Usage:
//   Drive a command with i_start; it is taken at a rising edge where i_start
//   is high and o_busy is low. Every transaction yields exactly one result,
//   shown for one cycle with o_valid high; the receiver cannot stall it.
//   Append and clear: result in the cycle after the start edge, no busy time.
//   Check: the request enters a row of RULES cells, one rule per cell, and
//   moves one cell per clock; the first matching rule marks the token. The
//   request is registered at the row entry, in each cell and at the output,
//   and o_busy is high until the result is registered, so no new command is
//   taken before the check result is out; the length of the cell row sets this.
//   i_cfg_wr_en writes the enforcing bit; write it only while idle.
//   Reset (synchronous, active low) empties the table and sets enforcing.
//   Rule contents are not cleared; only rules below the count are visited.
module first_match_access_rule_table
    import fmart_pkg::*;
#(
    parameter int RULES     = RULES_DEF,
    parameter int TYPE_BITS = TYPE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_subject_type,
    input  logic [7:0]  i_object_type,
    input  logic [7:0]  i_action_id,
    input  logic        i_subject_any,
    input  logic        i_object_any,
    input  logic        i_rule_allow,
    input  logic        i_rule_not_owner,
    input  logic [31:0] i_subject_uid,
    input  logic [31:0] i_object_uid,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic        o_matched,
    output logic [7:0]  o_rule_index,
    output logic [8:0]  o_rule_total
);

    localparam int CW = $clog2(RULES + 1);
    localparam int IW = (RULES > 1) ? $clog2(RULES) : 1;

    logic [CW-1:0]        r_fill;
    logic                 r_busy;
    logic                 r_enforcing;
    t_tok_flags           r_ent_flags;
    logic [TYPE_BITS-1:0] r_ent_subj;
    logic [TYPE_BITS-1:0] r_ent_obj;
    logic [7:0]           r_ent_act;
    logic [CW-1:0]        r_ent_left;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic                 r_out_matched;
    logic [7:0]           r_out_idx;
    logic [8:0]           r_out_total;

    logic [CW-1:0]        n_fill;
    logic                 n_busy;
    t_tok_flags           n_ent_flags;
    logic                 n_out_valid;
    t_status              n_out_status;
    logic                 n_out_matched;
    logic [7:0]           n_out_idx;
    logic [8:0]           n_out_total;

    logic                 accept;
    logic                 full;
    logic                 wr_en;
    t_cmd                 cmd;
    logic [TYPE_BITS-1:0] in_subj;
    logic [TYPE_BITS-1:0] in_obj;
    t_rule_bits           in_bits;

    t_tok_flags           c_flags [0:RULES];
    logic [TYPE_BITS-1:0] c_subj  [0:RULES];
    logic [TYPE_BITS-1:0] c_obj   [0:RULES];
    logic [7:0]           c_act   [0:RULES];
    logic [CW-1:0]        c_left  [0:RULES];
    logic [IW-1:0]        c_idx   [0:RULES];
    logic [RULES:0]       tok_valid;

    assign accept  = i_start && !r_busy;
    assign cmd     = t_cmd'(i_command);
    assign full    = (r_fill == CW'(RULES));
    assign wr_en   = accept && (cmd == CMD_APPEND) && !full;
    assign in_subj = TYPE_BITS'(i_subject_type);
    assign in_obj  = TYPE_BITS'(i_object_type);
    assign in_bits = '{subj_any: i_subject_any, obj_any: i_object_any,
                       allow: i_rule_allow, not_owner: i_rule_not_owner};

    assign c_flags[0] = r_ent_flags;
    assign c_subj[0]  = r_ent_subj;
    assign c_obj[0]   = r_ent_obj;
    assign c_act[0]   = r_ent_act;
    assign c_left[0]  = r_ent_left;
    assign c_idx[0]   = '0;

    for (genvar g = 0; g < RULES; g++) begin : g_cell
        fmart_cell #(
            .RULES     (RULES),
            .TYPE_BITS (TYPE_BITS),
            .CELL_IDX  (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (wr_en),
            .i_wr_addr (r_fill),
            .i_wr_subj (in_subj),
            .i_wr_obj  (in_obj),
            .i_wr_act  (i_action_id),
            .i_wr_bits (in_bits),
            .i_flags   (c_flags[g]),
            .i_subj    (c_subj[g]),
            .i_obj     (c_obj[g]),
            .i_act     (c_act[g]),
            .i_left    (c_left[g]),
            .i_idx     (c_idx[g]),
            .o_flags   (c_flags[g+1]),
            .o_subj    (c_subj[g+1]),
            .o_obj     (c_obj[g+1]),
            .o_act     (c_act[g+1]),
            .o_left    (c_left[g+1]),
            .o_idx     (c_idx[g+1])
        );
    end

    for (genvar v = 0; v <= RULES; v++) begin : g_tok_valid
        assign tok_valid[v] = c_flags[v].valid;
    end

    always_comb begin
        n_fill        = r_fill;
        n_busy        = r_busy;
        n_ent_flags   = '0;
        n_out_valid   = 1'b0;
        n_out_status  = r_out_status;
        n_out_matched = r_out_matched;
        n_out_idx     = r_out_idx;
        n_out_total   = r_out_total;

        // Token leaving the last cell carries the decision.
        if (c_flags[RULES].valid) begin
            n_busy        = 1'b0;
            n_out_valid   = 1'b1;
            n_out_matched = c_flags[RULES].hit;
            n_out_total   = 9'(r_fill);
            if (c_flags[RULES].hit) begin
                n_out_status = c_flags[RULES].allow ? ST_ALLOW : ST_DENY;
                n_out_idx    = 8'(c_idx[RULES]);
            end else begin
                n_out_status = r_enforcing ? ST_DENY : ST_ALLOW;
                n_out_idx    = 8'd0;
            end
        end

        if (accept) begin
            n_out_matched = 1'b0;
            n_out_idx     = 8'd0;
            n_out_status  = ST_ALLOW;
            case (cmd)
                CMD_APPEND: begin
                    n_out_valid = 1'b1;
                    if (full) begin
                        n_out_status = ST_FULL;
                    end else begin
                        n_fill = r_fill + CW'(1);
                    end
                end
                CMD_CHECK: begin
                    n_busy             = 1'b1;
                    n_ent_flags.valid  = 1'b1;
                    n_ent_flags.uid_ne = (i_subject_uid != i_object_uid);
                end
                CMD_CLEAR: begin
                    n_out_valid = 1'b1;
                    n_fill      = '0;
                end
                default: begin
                    n_out_valid = 1'b1;
                end
            endcase
            n_out_total = 9'(n_fill);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_busy      <= 1'b0;
            r_enforcing <= 1'b1;
            r_ent_flags <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_busy      <= n_busy;
            r_ent_flags <= n_ent_flags;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_enforcing <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ent_subj <= in_subj;
            r_ent_obj  <= in_obj;
            r_ent_act  <= i_action_id;
            r_ent_left <= r_fill;
        end
        r_out_status  <= n_out_status;
        r_out_matched <= n_out_matched;
        r_out_idx     <= n_out_idx;
        r_out_total   <= n_out_total;
    end

    assign o_busy       = r_busy;
    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_matched    = r_out_matched;
    assign o_rule_index = r_out_idx;
    assign o_rule_total = r_out_total;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(RULES))
        else $error("rule count exceeds table size");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_valid))
        else $error("more than one check token in the cell row");

    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tok_valid != '0) |-> r_busy)
        else $error("check token in flight while not busy");

    a_check_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (cmd == CMD_CHECK)) |=> (r_busy && !r_out_valid))
        else $error("check did not hold the block busy");

endmodule
